>>> rtl/lnhb_pkg.sv
// Shared constants and types for the circular history buffer.
`timescale 1ns / 1ps

package lnhb_pkg;

   // Number of entries held by the log (2..64).
   localparam int unsigned DEPTH  = 64;
   localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned ID_W   = 32;
   localparam int unsigned WANT_W = 16;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam ptr_type PTR_LAST = ptr_type'(DEPTH - 1);
   localparam cnt_type CNT_FULL = cnt_type'(DEPTH);

   // Item kinds.
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Read job handed from the front end to the read engine.
   typedef struct packed {
      ptr_type start_pos;
      cnt_type count;
   } cmd_type;

   // Occupancy seen by the front end.
   typedef struct packed {
      logic q_full;
      logic q_empty;
      logic back_run;
   } occ_type;

endpackage

>>> rtl/lnhb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lnhb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/lnhb_front.sv
// Front end: takes items, writes records, turns queries into read jobs.
`timescale 1ns / 1ps

module lnhb_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic signed [lnhb_pkg::ID_W-1:0] req_order_id,
   input  logic [lnhb_pkg::WANT_W-1:0]      req_want_count,
   input  lnhb_pkg::occ_type                occ,
   output logic                             cmd_push,
   output lnhb_pkg::cmd_type                cmd,
   output logic                             ram_we,
   output lnhb_pkg::ptr_type                ram_waddr,
   output logic [lnhb_pkg::ID_W-1:0]        ram_wdata
);

   lnhb_pkg::ptr_type wp_ff, wp_in;
   lnhb_pkg::cnt_type fill_ff, fill_in;
   // records that may still land without clobbering an unread entry
   lnhb_pkg::cnt_type slack_ff, slack_in;

   logic              accept, is_rec, is_qry, idle;
   lnhb_pkg::cnt_type n_clamp, room, base;
   lnhb_pkg::cnt_type wp_wide, start_wide;

   assign busy   = occ.q_full | (slack_ff == '0);
   assign accept = start & ~busy;
   assign is_rec = accept & (req_kind == lnhb_pkg::KIND_RECORD);
   assign is_qry = accept & (req_kind == lnhb_pkg::KIND_QUERY);
   assign idle   = occ.q_empty & ~occ.back_run;

   // fill level never exceeds DEPTH, so it also covers the depth clamp
   assign n_clamp = (req_want_count > lnhb_pkg::WANT_W'(fill_ff)) ?
                    fill_ff : req_want_count[lnhb_pkg::CNT_W-1:0];

   assign wp_wide    = lnhb_pkg::cnt_type'(wp_ff);
   assign start_wide = (wp_wide >= n_clamp) ? (wp_wide - n_clamp)
                                            : ((lnhb_pkg::CNT_FULL - n_clamp) + wp_wide);

   assign cmd_push      = is_qry & (n_clamp != '0);
   assign cmd.start_pos = lnhb_pkg::ptr_type'(start_wide);
   assign cmd.count     = n_clamp;

   assign ram_we    = is_rec;
   assign ram_waddr = wp_ff;
   assign ram_wdata = req_order_id;

   assign room = lnhb_pkg::CNT_FULL - n_clamp;
   assign base = idle ? lnhb_pkg::CNT_FULL : slack_ff;

   always_comb begin
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      slack_in = base;
      if (is_rec) begin
         wp_in = (wp_ff == lnhb_pkg::PTR_LAST) ? '0 : wp_ff + lnhb_pkg::ptr_type'(1);
         if (fill_ff != lnhb_pkg::CNT_FULL) begin
            fill_in = fill_ff + lnhb_pkg::cnt_type'(1);
         end
         if (!idle) begin
            slack_in = slack_ff - lnhb_pkg::cnt_type'(1);
         end
      end else if (cmd_push) begin
         slack_in = (room < base) ? room : base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         fill_ff  <= '0;
         slack_ff <= lnhb_pkg::CNT_FULL;
      end else begin
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         slack_ff <= slack_in;
      end
   end

endmodule

>>> rtl/lnhb_cmd_fifo.sv
// Two-entry queue of read jobs between front end and read engine.
`timescale 1ns / 1ps

module lnhb_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lnhb_pkg::cmd_type cmd,
   input  logic              pop,
   output lnhb_pkg::cmd_type head,
   output logic              q_full,
   output logic              q_empty
);

   lnhb_pkg::cmd_type e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]        count_ff, count_in, after_pop;

   assign after_pop = count_ff - {1'b0, pop};
   assign count_in  = after_pop + {1'b0, push};

   always_comb begin
      e0_in = pop ? e1_ff : e0_ff;
      e1_in = e1_ff;
      if (push) begin
         if (after_pop == 2'd0) begin
            e0_in = cmd;
         end else begin
            e1_in = cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign head    = e0_ff;
   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);

endmodule

>>> rtl/lnhb_back.sv
// Read engine: walks one read job through the store, one entry a cycle.
`timescale 1ns / 1ps

module lnhb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  lnhb_pkg::cmd_type head,
   output logic              pop,
   output logic              back_run,
   output logic              rd_en,
   output lnhb_pkg::ptr_type rd_addr,
   output logic              rsp_valid,
   output logic              rsp_is_last
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type         state_ff;
   lnhb_pkg::ptr_type pos_ff;
   lnhb_pkg::cnt_type rem_ff;
   logic              valid_ff, last_ff;

   assign pop      = (state_ff == ST_IDLE) & ~q_empty;
   assign back_run = (state_ff == ST_RUN);
   assign rd_en    = back_run;
   assign rd_addr  = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  pos_ff   <= head.start_pos;
                  rem_ff   <= head.count;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               // data comes out of the RAM register next cycle
               valid_ff <= 1'b1;
               last_ff  <= (rem_ff == lnhb_pkg::cnt_type'(1));
               pos_ff   <= (pos_ff == lnhb_pkg::PTR_LAST) ? '0
                                                          : pos_ff + lnhb_pkg::ptr_type'(1);
               rem_ff   <= rem_ff - lnhb_pkg::cnt_type'(1);
               if (rem_ff == lnhb_pkg::cnt_type'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_is_last = last_ff;

endmodule

>>> rtl/last_n_history_buffer_top.sv
// Top level of the circular history buffer: last N recorded identifiers.
`timescale 1ns / 1ps
// Record: written as it is taken, no response; records stream at one per cycle unless busy.
// Query for n entries: the job goes through the job queue to the read engine, then entries
//   come out on rsp_ ports one per cycle, oldest first, through the one RAM read port.
// busy rises while two read jobs are queued, or while one more record could overwrite
//   an entry a pending query has not yet read.
// Reset is synchronous: clears write position, fill level and job queue; store not cleared.

module last_n_history_buffer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic signed [lnhb_pkg::ID_W-1:0] req_order_id,
   input  logic [lnhb_pkg::WANT_W-1:0]      req_want_count,
   output logic                             rsp_valid,
   output logic signed [lnhb_pkg::ID_W-1:0] rsp_entry_value,
   output logic                             rsp_is_last
);

   lnhb_pkg::occ_type occ;
   lnhb_pkg::cmd_type push_cmd, head_cmd;
   logic              cmd_push, cmd_pop, q_full, q_empty, back_run;

   logic                        ram_we, ram_re;
   lnhb_pkg::ptr_type           ram_waddr, ram_raddr;
   logic [lnhb_pkg::ID_W-1:0]   ram_wdata, ram_rdata;

   assign occ.q_full   = q_full;
   assign occ.q_empty  = q_empty;
   assign occ.back_run = back_run;

   // Front end: records go straight into the store, queries become read jobs.
   lnhb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_order_id   (req_order_id),
      .req_want_count (req_want_count),
      .occ            (occ),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata)
   );

   lnhb_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .cmd     (push_cmd),
      .pop     (cmd_pop),
      .head    (head_cmd),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   // Read engine: one store read per cycle while a job runs.
   lnhb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head        (head_cmd),
      .pop         (cmd_pop),
      .back_run    (back_run),
      .rd_en       (ram_re),
      .rd_addr     (ram_raddr),
      .rsp_valid   (rsp_valid),
      .rsp_is_last (rsp_is_last)
   );

   lnhb_ram #(
      .WIDTH (lnhb_pkg::ID_W),
      .DEPTH (lnhb_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_entry_value = signed'(ram_rdata);

   // A record must never land on the entry the read engine is fetching.
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("record write hit the entry being read");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("read job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !q_empty)
      else $error("read job popped from an empty queue");

   // The response after a last entry can only open a new job, so no strobe follows directly.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |=> !rsp_valid)
      else $error("transfer directly after last entry of a run");

endmodule

>>> tb/last_n_history_buffer_top_tb.sv
// Self-checking testbench for the circular history buffer: record/query traffic.
`timescale 1ns / 1ps

module last_n_history_buffer_top_tb;
   import lnhb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 212;
   // Leave a generous margin after the last entry.
   localparam int unsigned TAIL_CYCLES = 20;

   // Shadow copy of the log. Each accepted item updates it; a query appends the
   // entries it should return (oldest first) to the due queues, and each
   // rsp_valid transfer is matched against the oldest one.
   class history_shadow;
      logic signed [ID_W-1:0] slots [DEPTH];
      int unsigned            wr_pos;
      int unsigned            fill;
      logic signed [ID_W-1:0] due_value [$];
      logic                   due_last [$];
      int unsigned            errors;

      function new();
         wr_pos = 0;
         fill   = 0;
         errors = 0;
      endfunction

      function void take_item(logic kind, logic signed [ID_W-1:0] id,
                              logic [WANT_W-1:0] want);
         int unsigned n;
         int unsigned pos;
         if (kind == KIND_RECORD) begin
            slots[wr_pos] = id;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (fill < DEPTH) fill++;
         end else begin
            // clamp to depth and to what is held; zero means no response
            n = want;
            if (n > DEPTH) n = DEPTH;
            if (n > fill) n = fill;
            pos = (wr_pos + DEPTH - n) % DEPTH;
            for (int unsigned k = 0; k < n; k++) begin
               due_value = {due_value, slots[pos]};
               due_last  = {due_last, logic'(k + 1 == n)};
               pos = (pos + 1) % DEPTH;
            end
         end
      endfunction

      function void match_entry(logic signed [ID_W-1:0] value, logic last);
         logic signed [ID_W-1:0] exp_value;
         logic                   exp_last;
         if (due_value.size() == 0) begin
            $error("unexpected entry: entry_value=%0d is_last=%0b", value, last);
            errors++;
            return;
         end
         exp_value = due_value.pop_front();
         exp_last  = due_last.pop_front();
         if (value !== exp_value) begin
            $error("entry_value mismatch: expected %0d, actual %0d", exp_value, value);
            errors++;
         end
         if (last !== exp_last) begin
            $error("is_last mismatch: expected %0b, actual %0b", exp_last, last);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return due_value.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_kind = KIND_RECORD;
   logic signed [ID_W-1:0] req_order_id = '0;
   logic [WANT_W-1:0]      req_want_count = '0;
   logic                   rsp_valid;
   logic signed [ID_W-1:0] rsp_entry_value;
   logic                   rsp_is_last;

   history_shadow shadow = new();
   int unsigned   accepted = 0;
   int unsigned   cycles = 0;
   bit            quiet = 1'b0;   // set: sender never idles

   always #6 clock = ~clock;

   last_n_history_buffer_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_order_id    (req_order_id),
      .req_want_count  (req_want_count),
      .rsp_valid       (rsp_valid),
      .rsp_entry_value (rsp_entry_value),
      .rsp_is_last     (rsp_is_last)
   );

   // Sample both channels at the rising edge. A response can never belong to an
   // item taken at the same edge, so checking first is safe.
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid) shadow.match_entry(rsp_entry_value, rsp_is_last);
         if (start && !busy) begin
            shadow.take_item(req_kind, req_order_id, req_want_count);
            accepted++;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   // Inputs are held while busy stalls the transfer.
   task automatic send_item(logic kind, logic signed [ID_W-1:0] id, logic [WANT_W-1:0] want);
      int unsigned seen;
      // each cycle idles with a 17% chance
      while (!quiet && $urandom_range(0, 99) < 17) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_kind       = kind;
      req_order_id   = id;
      req_want_count = want;
      seen = accepted;
      do @(negedge clock); while (accepted == seen);
   endtask

   // Sender holds off until every queued entry has come back.
   task automatic drain();
      start = 1'b0;
      while (shadow.pending() != 0) @(negedge clock);
   endtask

   task automatic send_record(logic signed [ID_W-1:0] id);
      send_item(KIND_RECORD, id, WANT_W'($urandom));
   endtask

   task automatic send_query(logic [WANT_W-1:0] want);
      send_item(KIND_QUERY, ID_W'($urandom), want);
   endtask

   // Mostly short reads; some up to the depth, some far beyond it, a few zero.
   function automatic logic [WANT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return WANT_W'($urandom_range(1, 8));
      if (r < 72) return WANT_W'($urandom_range(9, DEPTH));
      if (r < 80) return WANT_W'($urandom_range(DEPTH + 1, DEPTH + 8));
      if (r < 92) return WANT_W'($urandom);
      return '0;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // empty log: no response whatever the count
      send_query(WANT_W'(1));
      send_query('1);
      // extremes of the identifier; want_count on a record is ignored
      send_item(KIND_RECORD, 32'sh8000_0000, '1);
      send_query('0);                            // zero count
      send_query(WANT_W'(1));
      send_item(KIND_RECORD, 32'sh7FFF_FFFF, '0);
      send_record(32'sh0000_0000);
      send_record(32'shFFFF_FFFF);
      send_query(WANT_W'(2));
      send_query(WANT_W'(4));                    // exactly the fill level
      send_item(KIND_QUERY, 32'shFFFF_FFFF, '1); // oversized; order_id ignored
      send_query(WANT_W'(DEPTH + 1));
      repeat (8) send_record(ID_W'($urandom));
      send_query(16'h8000);
      send_query(WANT_W'(DEPTH));
      send_query(16'h5555);
      send_query(16'h00AA);
      drain();

      // --- random part ---
      // Records dominate so the log fills and wraps; a long stretch runs with
      // no sender idling so busy back-pressure gets exercised.
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 80 && i < 150);
         if (i == 170) drain();
         if ($urandom_range(0, 99) < 72) send_record(ID_W'($urandom));
         else send_query(pick_count());
      end
      start = 1'b0;
      quiet = 1'b0;

      // --- wind down ---
      while (shadow.pending() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (shadow.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
